// ----- hdl/fixed_point_alu_top_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the fixed-point alu
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_TOP_ASSERT_SVH

// condition in the same cycle
`define FPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fixed_point_alu: assertion failed");

// condition in the following cycle
`define FPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fixed_point_alu: assertion failed");

`endif

// ----- hdl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the signed fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

	// default word layout
	localparam int WORD_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// operation codes
	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_NEG = 3'd2,
		KIND_MUL = 3'd3,
		KIND_DIV = 3'd4,
		KIND_MIN = 3'd5,
		KIND_MAX = 3'd6
	} fpa_kind_t;

	// request transaction
	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} fpa_req_t;

	// response transaction
	typedef struct packed {
		logic signed [31:0] value;
		logic               is_less;
		logic               is_equal;
		logic               is_greater;
		logic               divide_by_zero;
	} fpa_rsp_t;

	// control travelling with each item down the divider chain
	typedef struct packed {
		logic valid;
		logic is_div;
		logic q_neg;
		logic div_zero;
		logic is_less;
		logic is_equal;
		logic is_greater;
	} fpa_ctl_t;

endpackage

// ----- hdl/fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// signed fixed-point alu: add, sub, neg, mul, div, min, max with compare flags
// ----------------------------------------------------------------------------
//  channel | signals                   | payload
//  req     | req_valid, req_ready      | fpa_req_t: kind, operand_a, operand_b
//  rsp     | rsp_valid, rsp_ready      | fpa_rsp_t: value, flags, divide_by_zero
//
//  one transaction per cycle while req_ready is high; every item passes through
//  two front stages, one divider cell per quotient bit and the output register
//  every operation travels the divider cell chain, which sets the latency
//  reset clears only the valid and control flags; no clearing pass
//  a held response fills the skid stage, after which req_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fixed_point_alu_top_assert.svh"

module fixed_point_alu_top #(
	parameter int WORD_WIDTH    = fpa_pkg::WORD_WIDTH_DEF,
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fpa_pkg::fpa_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fpa_pkg::fpa_rsp_t rsp
);

	localparam int NCELL = WORD_WIDTH + FRACTION_BITS;

	logic                  advance;
	fpa_pkg::fpa_ctl_t     ctl_c   [0:NCELL];
	logic [WORD_WIDTH-1:0] rem_c   [0:NCELL];
	logic [WORD_WIDTH-1:0] quot_c  [0:NCELL];
	logic [WORD_WIDTH-1:0] a_mag_c [0:NCELL];
	logic [WORD_WIDTH-1:0] b_mag_c [0:NCELL];

	assign req_ready = advance;
	assign rem_c[0]  = '0;

	// decode, simple operations and multiplier
	fpa_front #(
		.WORD_WIDTH    (WORD_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.req_valid (req_valid),
		.req       (req),
		.ctl       (ctl_c[0]),
		.quot      (quot_c[0]),
		.a_mag     (a_mag_c[0]),
		.b_mag     (b_mag_c[0])
	);

	// divider chain, one quotient bit per cell
	generate
		for (genvar i = 0; i < NCELL; i++) begin : g_cell
			fpa_div_cell #(
				.WORD_WIDTH (WORD_WIDTH),
				.INDEX      (i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (advance),
				.ctl_i   (ctl_c[i]),
				.rem_i   (rem_c[i]),
				.quot_i  (quot_c[i]),
				.a_mag_i (a_mag_c[i]),
				.b_mag_i (b_mag_c[i]),
				.ctl_o   (ctl_c[i+1]),
				.rem_o   (rem_c[i+1]),
				.quot_o  (quot_c[i+1]),
				.a_mag_o (a_mag_c[i+1]),
				.b_mag_o (b_mag_c[i+1])
			);
		end
	endgenerate

	// sign fix-up and response buffering
	fpa_out #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_c[NCELL]),
		.quot      (quot_c[NCELL]),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// checks
	`FPA_ASSERT_NOW(a_dz_zero, rsp_valid && rsp.divide_by_zero, rsp.value == 32'sd0)
	`FPA_ASSERT_NOW(a_one_flag, rsp_valid, $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}))
	`FPA_ASSERT_NOW(a_stall_full, !req_ready, rsp_valid)
	`FPA_ASSERT_NEXT(a_stall_hold, !req_ready && !rsp_ready, rsp_valid && !req_ready)

endmodule

// ----- hdl/fpa_front.sv -----
// ----------------------------------------------------------------------------
// fpa_front
// operand decode, simple operations, multiplier and divider set-up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front #(
	parameter int WORD_WIDTH    = fpa_pkg::WORD_WIDTH_DEF,
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  req_valid,
	input  fpa_pkg::fpa_req_t     req,
	output fpa_pkg::fpa_ctl_t     ctl,
	output logic [WORD_WIDTH-1:0] quot,
	output logic [WORD_WIDTH-1:0] a_mag,
	output logic [WORD_WIDTH-1:0] b_mag
);

	// product wide enough to hold the scaled slice for any fraction width
	localparam int PW = (FRACTION_BITS > WORD_WIDTH) ?
		(WORD_WIDTH + FRACTION_BITS) : (2 * WORD_WIDTH);

	logic signed [WORD_WIDTH-1:0] a_w, b_w;
	logic [WORD_WIDTH-1:0]        simple;
	logic signed [PW-1:0]         prod;

	logic                         valid_s1;
	fpa_pkg::fpa_kind_t           kind_s1;
	logic signed [WORD_WIDTH-1:0] a_s1, b_s1;
	logic [WORD_WIDTH-1:0]        simple_s1;
	logic signed [PW-1:0]         prod_s1;
	logic                         less_s1, equal_s1, greater_s1;

	fpa_pkg::fpa_ctl_t            ctl_s2;
	logic [WORD_WIDTH-1:0]        quot_s2, a_mag_s2, b_mag_s2;

	// operands narrowed to the word
	assign a_w  = req.operand_a[WORD_WIDTH-1:0];
	assign b_w  = req.operand_b[WORD_WIDTH-1:0];
	assign prod = PW'(a_w) * PW'(b_w);

	// add, subtract, negate, minimum, maximum
	always_comb begin
		case (fpa_pkg::fpa_kind_t'(req.kind))
			fpa_pkg::KIND_ADD: simple = a_w + b_w;
			fpa_pkg::KIND_SUB: simple = a_w - b_w;
			fpa_pkg::KIND_NEG: simple = -a_w;
			fpa_pkg::KIND_MIN: simple = (a_w < b_w) ? a_w : b_w;
			fpa_pkg::KIND_MAX: simple = (a_w > b_w) ? a_w : b_w;
			default:           simple = '0;
		endcase
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1    <= fpa_pkg::fpa_kind_t'(req.kind);
			a_s1       <= a_w;
			b_s1       <= b_w;
			simple_s1  <= simple;
			prod_s1    <= prod;
			less_s1    <= (a_w < b_w);
			equal_s1   <= (a_w == b_w);
			greater_s1 <= (a_w > b_w);
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid      <= valid_s1;
			ctl_s2.is_div     <= (kind_s1 == fpa_pkg::KIND_DIV);
			ctl_s2.q_neg      <= a_s1[WORD_WIDTH-1] ^ b_s1[WORD_WIDTH-1];
			ctl_s2.div_zero   <= (kind_s1 == fpa_pkg::KIND_DIV) && (b_s1 == '0);
			ctl_s2.is_less    <= less_s1;
			ctl_s2.is_equal   <= equal_s1;
			ctl_s2.is_greater <= greater_s1;
		end
	end

	// stage 2 payload: scaled product or simple result, and operand magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2  <= (kind_s1 == fpa_pkg::KIND_MUL) ?
				prod_s1[FRACTION_BITS+WORD_WIDTH-1:FRACTION_BITS] : simple_s1;
			a_mag_s2 <= a_s1[WORD_WIDTH-1] ? -a_s1 : a_s1;
			b_mag_s2 <= b_s1[WORD_WIDTH-1] ? -b_s1 : b_s1;
		end
	end

	assign ctl   = ctl_s2;
	assign quot  = quot_s2;
	assign a_mag = a_mag_s2;
	assign b_mag = b_mag_s2;

endmodule

// ----- hdl/fpa_div_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_div_cell
// one restoring-division step; non-divide items pass through unchanged
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div_cell #(
	parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  fpa_pkg::fpa_ctl_t     ctl_i,
	input  logic [WORD_WIDTH-1:0] rem_i,
	input  logic [WORD_WIDTH-1:0] quot_i,
	input  logic [WORD_WIDTH-1:0] a_mag_i,
	input  logic [WORD_WIDTH-1:0] b_mag_i,
	output fpa_pkg::fpa_ctl_t     ctl_o,
	output logic [WORD_WIDTH-1:0] rem_o,
	output logic [WORD_WIDTH-1:0] quot_o,
	output logic [WORD_WIDTH-1:0] a_mag_o,
	output logic [WORD_WIDTH-1:0] b_mag_o
);

	logic                  dbit;
	logic [WORD_WIDTH:0]   trial, diff;
	logic                  ge;
	logic [WORD_WIDTH-1:0] rem_n, quot_n;

	fpa_pkg::fpa_ctl_t     ctl_q;
	logic [WORD_WIDTH-1:0] rem_q, quot_q, a_mag_q, b_mag_q;

	// dividend bit: magnitude of a, then the fraction zeros
	generate
		if (INDEX < WORD_WIDTH) begin : g_abit
			assign dbit = a_mag_i[WORD_WIDTH-1-INDEX];
		end else begin : g_zero
			assign dbit = 1'b0;
		end
	endgenerate

	// shift in, compare, subtract
	assign trial = {rem_i, dbit};
	assign diff  = trial - {1'b0, b_mag_i};
	assign ge    = (trial >= {1'b0, b_mag_i});

	always_comb begin
		if (ctl_i.is_div) begin
			rem_n  = ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
			quot_n = {quot_i[WORD_WIDTH-2:0], ge};
		end else begin
			rem_n  = rem_i;
			quot_n = quot_i;
		end
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= rem_n;
			quot_q  <= quot_n;
			a_mag_q <= a_mag_i;
			b_mag_q <= b_mag_i;
		end
	end

	assign ctl_o   = ctl_q;
	assign rem_o   = rem_q;
	assign quot_o  = quot_q;
	assign a_mag_o = a_mag_q;
	assign b_mag_o = b_mag_q;

endmodule

// ----- hdl/fpa_out.sv -----
// ----------------------------------------------------------------------------
// fpa_out
// quotient sign fix-up, output register and skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_out #(
	parameter int WORD_WIDTH = fpa_pkg::WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpa_pkg::fpa_ctl_t     ctl,
	input  logic [WORD_WIDTH-1:0] quot,
	output logic                  advance,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output fpa_pkg::fpa_rsp_t     rsp
);

	logic [WORD_WIDTH-1:0] val;
	fpa_pkg::fpa_rsp_t     fin;
	logic                  push, out_free;

	logic                  out_valid_q, skid_valid_q;
	fpa_pkg::fpa_rsp_t     out_q, skid_q;

	// final value
	always_comb begin
		if (!ctl.is_div) begin
			val = quot;
		end else if (ctl.div_zero) begin
			val = '0;
		end else begin
			val = ctl.q_neg ? -quot : quot;
		end
		fin.value          = 32'(signed'(val));
		fin.is_less        = ctl.is_less;
		fin.is_equal       = ctl.is_equal;
		fin.is_greater     = ctl.is_greater;
		fin.divide_by_zero = ctl.div_zero;
	end

	// chain moves while the skid stage is empty
	assign advance  = !skid_valid_q;
	assign push     = advance && ctl.valid;
	assign out_free = !out_valid_q || rsp_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : fin;
		end else if (push) begin
			skid_q <= fin;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
